@@ rtl/amr_pkg.sv @@
// Shared constants and types for the anchored pattern matcher.
package amr_pkg;

    localparam int MAX_PATTERN = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_REG_W  = 6;
    localparam int CH_W       = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // register indexes
    localparam t_cfg_idx CFG_PAT0 = 3'd0;
    localparam t_cfg_idx CFG_PAT1 = 3'd1;
    localparam t_cfg_idx CFG_PAT2 = 3'd2;
    localparam t_cfg_idx CFG_PAT3 = 3'd3;
    localparam t_cfg_idx CFG_LEN  = 3'd4;

    // item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // pattern symbols
    localparam logic [CH_W-1:0] SYM_STAR = 8'h2A;
    localparam logic [CH_W-1:0] SYM_SEP  = 8'h2E;
    localparam logic [CH_W-1:0] SYM_BAR  = 8'h7C;

    // per-cycle control shared by every cell
    typedef struct packed {
        logic fresh;   // active set is the start closure
        logic step;    // a text character is transferred this cycle
    } t_cell_ctrl;

    // link to the next cell
    typedef struct packed {
        logic st;      // start closure through a separator
        logic cl;      // step closure through a separator
        logic stp;     // unstarred literal consumed, advance one position
    } t_fwd1;

    // link to the cell two places on
    typedef struct packed {
        logic st;      // start closure skipping a starred literal
        logic cl;      // step closure skipping a starred literal
    } t_fwd2;

endpackage

@@ rtl/amr_cell.sv @@
// One pattern position of the NFA: decoded byte flags, start bit and active bit.
module amr_cell #(
    parameter int POS   = 0,
    parameter int POS_W = 6
) (
    input  logic                      i_clk,
    input  logic [amr_pkg::CH_W-1:0]  i_byte,
    input  logic [amr_pkg::CH_W-1:0]  i_byte_prev,
    input  logic [amr_pkg::CH_W-1:0]  i_byte_next,
    input  logic [POS_W-1:0]          i_len,
    input  logic                      i_has_bar,
    input  amr_pkg::t_cell_ctrl       i_ctrl,
    input  logic [amr_pkg::CH_W-1:0]  i_ch,
    input  amr_pkg::t_fwd1            i_fwd1,
    input  amr_pkg::t_fwd2            i_fwd2,
    output amr_pkg::t_fwd1            o_fwd1,
    output amr_pkg::t_fwd2            o_fwd2,
    output logic                      o_end_hit
);

    localparam logic [POS_W:0] POS_V = (POS_W+1)'(POS);
    localparam logic [POS_W:0] POS_N = (POS_W+1)'(POS + 1);

    logic                     r_lit, r_sep, r_star, r_end, r_seed, r_start, r_act;
    logic [amr_pkg::CH_W-1:0] r_byte;

    logic n_lit, n_sep, n_star, n_end, n_seed;
    logic lt, lt_next, le, is_bar, is_sep, first;
    logic act_eff, match, nv, v, sv;

    // decode, registered from the configuration every cycle
    always_comb begin
        lt      = POS_V < {1'b0, i_len};
        lt_next = POS_N < {1'b0, i_len};
        le      = POS_V <= {1'b0, i_len};
        is_bar  = (i_byte == amr_pkg::SYM_BAR);
        is_sep  = (i_byte == amr_pkg::SYM_SEP);
        first   = (POS == 0) || (i_byte_prev == amr_pkg::SYM_BAR);
        n_end   = !lt || is_bar;
        n_sep   = lt && is_sep;
        n_lit   = lt && !is_bar && !is_sep;
        n_star  = n_lit && lt_next && (i_byte_next == amr_pkg::SYM_STAR);
        n_seed  = first && le && !(i_has_bar && n_end);
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= i_byte;
        r_lit   <= n_lit;
        r_sep   <= n_sep;
        r_star  <= n_star;
        r_end   <= n_end;
        r_seed  <= n_seed;
        r_start <= sv;
        if (i_ctrl.step) begin
            r_act <= v;
        end
    end

    always_comb begin
        // start closure ripples along the row
        sv = r_seed | i_fwd1.st | i_fwd2.st;

        act_eff = i_ctrl.fresh ? r_start : r_act;
        match   = act_eff && r_lit && (r_byte == i_ch);
        nv      = (match && r_star) || i_fwd1.stp;
        v       = nv | i_fwd1.cl | i_fwd2.cl;

        o_fwd1.st  = sv && r_sep;
        o_fwd1.cl  = v && r_sep;
        o_fwd1.stp = match && !r_star;
        o_fwd2.st  = sv && r_star;
        o_fwd2.cl  = v && r_star;

        o_end_hit = act_eff && r_end;
    end

endmodule

@@ rtl/anchored_regex_matcher_top.sv @@
// Top level of the anchored pattern matcher: configuration, cell row and output stage.
//
// Text items arrive on i_in_valid / o_in_ready with i_kind and i_ch. A character
// (kind 0) updates the active-position vector and gives no result; an end-of-text
// item (kind 1) gives one result on o_out_valid / i_out_ready with o_accepted,
// then the matcher restarts for the next text.
// Throughput is one item per cycle while the input is not held off: the character
// update ripples combinationally through the row of MAX_PATTERN+1 position cells.
// The result of an end-of-text item is registered; it shows the cycle after its transfer.
// While a result waits and the receiver stalls, the input is held off for every
// item kind; it flows again in the cycle in which the receiver takes the result.
// Configuration writes on i_cfg_we / i_cfg_index / i_cfg_data take effect at once
// in the registers; the input is held off after each write to a defined register
// (and after reset) while the byte decode and then the start closure are rebuilt.
// Reset clears the pattern to empty, drops any pending result and restarts.
module anchored_regex_matcher_top #(
    parameter int MAX_PATTERN = amr_pkg::MAX_PATTERN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [amr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [amr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_kind,
    input  logic [amr_pkg::CH_W-1:0]        i_ch,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_accepted
);

    localparam int POS_W = $clog2(MAX_PATTERN + 1);
    localparam logic [1:0] HOLD_CYCLES = 2'd2;

    logic [amr_pkg::CH_W-1:0]      r_pat [MAX_PATTERN];
    logic [amr_pkg::LEN_REG_W-1:0] r_len;
    logic [1:0]                    r_hold;
    logic                          r_fresh;
    logic                          r_out_valid;
    logic                          r_accepted;

    logic [POS_W-1:0]          len_eff;
    logic [MAX_PATTERN-1:0]    bar_hits;
    logic                      has_bar;
    logic                      cfg_hit;
    logic                      in_xfer;
    logic                      acc;
    logic [MAX_PATTERN:0]      end_hits;
    amr_pkg::t_cell_ctrl       ctrl;
    amr_pkg::t_fwd1            fwd1 [MAX_PATTERN+1];
    amr_pkg::t_fwd2            fwd2 [MAX_PATTERN+1];

    // pattern bytes
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < MAX_PATTERN; b++) begin
            if (!i_rst_n) begin
                r_pat[b] <= '0;
            end else if (i_cfg_we && i_cfg_index == amr_pkg::CFG_PAT0 + 3'(b / 8)) begin
                r_pat[b] <= i_cfg_data[8*(b%8) +: 8];
            end
        end
    end

    for (genvar b = 0; b < MAX_PATTERN; b++) begin : g_pat
        assign bar_hits[b] = (POS_W'(b) < len_eff) && (r_pat[b] == amr_pkg::SYM_BAR);
    end

    assign len_eff = (r_len > amr_pkg::LEN_REG_W'(MAX_PATTERN)) ? POS_W'(MAX_PATTERN)
                                                               : r_len[POS_W-1:0];
    assign has_bar = |bar_hits;

    always_comb begin
        case (i_cfg_index)
            amr_pkg::CFG_PAT0,
            amr_pkg::CFG_PAT1,
            amr_pkg::CFG_PAT2,
            amr_pkg::CFG_PAT3,
            amr_pkg::CFG_LEN:  cfg_hit = i_cfg_we;
            default:           cfg_hit = 1'b0;
        endcase
    end

    assign o_in_ready = (r_hold == 2'd0) && (!r_out_valid || i_out_ready);
    assign in_xfer    = i_in_valid && o_in_ready;

    assign ctrl.fresh = r_fresh;
    assign ctrl.step  = in_xfer && (i_kind == amr_pkg::KIND_CHAR);

    // row of position cells, the last one holds no pattern byte and only ever marks an end
    for (genvar p = 0; p <= MAX_PATTERN; p++) begin : g_cell
        logic [amr_pkg::CH_W-1:0] byte_own, byte_prev, byte_next;
        amr_pkg::t_fwd1           fwd1_in;
        amr_pkg::t_fwd2           fwd2_in;

        if (p < MAX_PATTERN) begin : g_own
            assign byte_own = r_pat[p];
        end else begin : g_own_none
            assign byte_own = '0;
        end
        if (p + 1 < MAX_PATTERN) begin : g_next
            assign byte_next = r_pat[p+1];
        end else begin : g_next_none
            assign byte_next = '0;
        end
        if (p > 0) begin : g_prev
            assign byte_prev = r_pat[p-1];
            assign fwd1_in   = fwd1[p-1];
        end else begin : g_prev_none
            assign byte_prev = '0;
            assign fwd1_in   = '0;
        end
        if (p > 1) begin : g_prev2
            assign fwd2_in = fwd2[p-2];
        end else begin : g_prev2_none
            assign fwd2_in = '0;
        end

        amr_cell #(
            .POS   (p),
            .POS_W (POS_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_byte      (byte_own),
            .i_byte_prev (byte_prev),
            .i_byte_next (byte_next),
            .i_len       (len_eff),
            .i_has_bar   (has_bar),
            .i_ctrl      (ctrl),
            .i_ch        (i_ch),
            .i_fwd1      (fwd1_in),
            .i_fwd2      (fwd2_in),
            .o_fwd1      (fwd1[p]),
            .o_fwd2      (fwd2[p]),
            .o_end_hit   (end_hits[p])
        );
    end

    assign acc = |end_hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_hold      <= HOLD_CYCLES;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
            r_accepted  <= 1'b0;
        end else begin
            if (r_hold != 2'd0) begin
                r_hold <= r_hold - 2'd1;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_xfer) begin
                if (i_kind == amr_pkg::KIND_END) begin
                    r_out_valid <= 1'b1;
                    r_accepted  <= acc;
                    r_fresh     <= 1'b1;
                end else begin
                    r_fresh <= 1'b0;
                end
            end
            // user writes only while idle, not enforced; a defined register write restarts
            if (cfg_hit) begin
                r_hold  <= HOLD_CYCLES;
                r_fresh <= 1'b1;
                if (i_cfg_index == amr_pkg::CFG_LEN) begin
                    r_len <= i_cfg_data[amr_pkg::LEN_REG_W-1:0];
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;

endmodule

@@ verif/amr_tb_pkg.sv @@
// Scoreboard for the anchored pattern matcher: shadow NFA and queue of due verdicts.
package amr_tb_pkg;
    import amr_pkg::*;

    class match_scoreboard;
        logic [CFG_DATA_W-1:0] pat_words[4];
        logic [LEN_REG_W-1:0]  pat_len;
        logic [MAX_PATTERN:0]  live_pos;
        logic                  verdicts_due[$];
        int                    errors;

        function new();
            foreach (pat_words[i]) pat_words[i] = '0;
            pat_len = '0;
            errors = 0;
            live_pos = start_closure();
        endfunction

        function int used_len();
            return (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
        endfunction

        function logic [CH_W-1:0] sym_at(int i);
            int k;
            k = i & 31;
            return pat_words[k >> 3][(k & 7) * 8 +: 8];
        endfunction

        function bit alt_end(int p, int n);
            return p >= n || sym_at(p) == SYM_BAR;
        endfunction

        function bit starred(int p, int n);
            return sym_at(p) != SYM_SEP && p + 1 < n && sym_at(p + 1) == SYM_STAR;
        endfunction

        // follow separators and skip starred literals; only ever moves forward
        function logic [MAX_PATTERN:0] close_over(logic [MAX_PATTERN:0] v);
            int n;
            n = used_len();
            for (int p = 0; p <= n; p++) begin
                if (!v[p] || alt_end(p, n)) continue;
                if (sym_at(p) == SYM_SEP) v[p + 1] = 1'b1;
                else if (starred(p, n)) v[p + 2] = 1'b1;
            end
            return v;
        endfunction

        function logic [MAX_PATTERN:0] start_closure();
            int n;
            bit has_bar;
            logic [MAX_PATTERN:0] v;
            n = used_len();
            has_bar = 1'b0;
            v = '0;
            for (int p = 0; p < n; p++)
                if (sym_at(p) == SYM_BAR) has_bar = 1'b1;
            for (int p = 0; p <= n; p++) begin
                if (p != 0 && sym_at(p - 1) != SYM_BAR) continue;
                // empty alternatives only drop out when a bar is present
                if (has_bar && alt_end(p, n)) continue;
                v[p] = 1'b1;
            end
            return close_over(v);
        endfunction

        function void apply_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: begin
                    pat_words[idx] = data;
                end
                CFG_LEN: begin
                    pat_len = data[LEN_REG_W-1:0];
                end
                default: begin
                    return;
                end
            endcase
            live_pos = start_closure();
        endfunction

        function void note_item(logic kind, logic [CH_W-1:0] ch);
            int n;
            logic hit;
            logic [MAX_PATTERN:0] nxt;
            n = used_len();
            hit = 1'b0;
            nxt = '0;
            if (kind == KIND_END) begin
                for (int p = 0; p <= n; p++)
                    if (live_pos[p] && alt_end(p, n)) hit = 1'b1;
                verdicts_due.push_back(hit);
                live_pos = start_closure();
            end else begin
                for (int p = 0; p < n; p++) begin
                    if (!live_pos[p] || alt_end(p, n)) continue;
                    if (sym_at(p) == SYM_SEP || sym_at(p) != ch) continue;
                    if (starred(p, n)) nxt[p] = 1'b1;
                    else nxt[p + 1] = 1'b1;
                end
                live_pos = close_over(nxt);
            end
        endfunction

        function void check_result(logic accepted);
            logic want;
            if (verdicts_due.size() == 0) begin
                $error("accepted: no result expected, got %0b", accepted);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (accepted !== want) begin
                $error("accepted: expected %0b, got %0b", want, accepted);
                errors++;
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

endpackage

@@ verif/tb_anchored_regex_matcher_top.sv @@
// Testbench top for the anchored pattern matcher: drivers, monitor and test sequence.
module tb_anchored_regex_matcher_top;
    timeunit 1ns;
    timeprecision 1ps;

    import amr_pkg::*;
    import amr_tb_pkg::*;

    localparam int       TOTAL_ITEMS  = 1725;
    localparam int       HOLD_CYCLES  = 300;
    localparam int       LIMIT_CYCLES = 200000;
    localparam t_cfg_idx CFG_SPARE    = 3'd5;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_kind;
    logic [CH_W-1:0]       i_ch;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_accepted;

    match_scoreboard sb;

    int         tx_idle_pct = 30;
    int         rx_idle_pct = 30;
    bit         hold_req = 1'b0;
    int         items_sent = 0;
    int         cycles = 0;
    logic [7:0] pat_buf[32];
    logic [5:0] pat_len_w;
    logic [7:0] text_q[$];

    anchored_regex_matcher_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_ch        (i_ch),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_accepted  (o_accepted)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_item(i_kind, i_ch);
            if (o_out_valid && i_out_ready) sb.check_result(o_accepted);
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int held;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // '~' stands for byte 0x00 and '#' for 0xFF in directed strings
    function automatic logic [7:0] glyph(byte c);
        if (c == "~") return 8'h00;
        if (c == "#") return 8'hFF;
        return c;
    endfunction

    function automatic logic [7:0] pick_sym();
        int r;
        r = $urandom_range(99);
        if (r < 20) return "a";
        if (r < 40) return "b";
        if (r < 52) return "c";
        if (r < 60) return 8'h00;
        if (r < 68) return 8'hFF;
        if (r < 82) return SYM_STAR;
        if (r < 91) return SYM_SEP;
        return SYM_BAR;
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(1) == 0) return pick_sym();
        return 8'($urandom_range(255));
    endfunction

    function automatic void make_pattern();
        int r;
        int n;
        for (int i = 0; i < 32; i++) pat_buf[i] = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 5) pat_len_w = 6'd0;
        else if (r < 12) pat_len_w = 6'd32;
        else if (r < 18) pat_len_w = 6'($urandom_range(33, 63));
        else pat_len_w = 6'($urandom_range(1, 12));
        n = (pat_len_w > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len_w);
        for (int i = 0; i < n; i++) pat_buf[i] = pick_sym();
    endfunction

    // mostly a text that walks one alternative, sometimes damaged, sometimes noise
    function automatic void build_text();
        int n;
        int p;
        int r;
        int starts[$];
        bit has_bar;
        logic [7:0] b;
        text_q.delete();
        n = (pat_len_w > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len_w);
        has_bar = 1'b0;
        for (p = 0; p < n; p++)
            if (pat_buf[p] == SYM_BAR) has_bar = 1'b1;
        for (p = 0; p <= n; p++) begin
            if (p != 0 && pat_buf[p - 1] != SYM_BAR) continue;
            if (has_bar && (p >= n || pat_buf[p] == SYM_BAR)) continue;
            starts.push_back(p);
        end
        if (starts.size() == 0 || $urandom_range(99) < 15) begin
            repeat ($urandom_range(0, 6)) text_q.push_back(noise_byte());
            return;
        end
        p = starts[$urandom_range(starts.size() - 1)];
        while (p < n && pat_buf[p] != SYM_BAR) begin
            b = pat_buf[p];
            if (b == SYM_SEP) begin
                p++;
            end else if (p + 1 < n && pat_buf[p + 1] == SYM_STAR) begin
                repeat ($urandom_range(0, 3)) text_q.push_back(b);
                p += 2;
            end else begin
                text_q.push_back(b);
                p++;
            end
        end
        if ($urandom_range(99) < 25) begin
            r = $urandom_range(2);
            if (r == 0 || text_q.size() == 0)
                text_q.insert($urandom_range(text_q.size()), noise_byte());
            else if (r == 1)
                text_q.delete($urandom_range(text_q.size() - 1));
            else
                text_q[$urandom_range(text_q.size() - 1)] = noise_byte();
        end
    endfunction

    task automatic send_item(input logic kind, input logic [CH_W-1:0] ch);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_kind = kind;
        i_ch = ch;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_item(KIND_CHAR, text_q[i]);
        send_item(KIND_END, CH_W'($urandom_range(255)));
    endtask

    task automatic send_str(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(glyph(s[i]));
        send_text();
    endtask

    // stop offering and let every outstanding verdict come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        sb.apply_reg(idx, data);
    endtask

    task automatic load_pattern();
        logic [CFG_DATA_W-1:0] w;
        drain();
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 8; k++) w[k * 8 +: 8] = pat_buf[r * 8 + k];
            cfg_write(t_cfg_idx'(r), w);
        end
        w = {$urandom, $urandom};
        w[LEN_REG_W-1:0] = pat_len_w;
        cfg_write(CFG_LEN, w);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_pattern_str(input string s);
        pat_len_w = 6'(s.len());
        for (int i = 0; i < 32; i++) pat_buf[i] = (i < s.len()) ? glyph(s[i]) : 8'h00;
        load_pattern();
    endtask

    initial begin
        int phase;
        int n_texts;
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_kind = KIND_CHAR;
        i_ch = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset pattern is empty: only the empty text should pass
        send_str("");
        send_str("~");
        // empty alternative, starred star, separator-only alternative
        set_pattern_str("~b*||**.c|..");
        send_str("");
        send_str("~bb");
        send_str("**c");
        send_str("c");
        send_str("b");
        // stray stars, top byte, empty text through a separator before a star
        set_pattern_str("*a|a**|#|.x*");
        send_str("*a");
        send_str("aa*");
        send_str("#");
        send_str("");
        // unused index must leave the pattern alone
        drain();
        cfg_write(CFG_SPARE, {$urandom, $urandom});
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        send_str("*a");

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            case (phase)
                0: begin
                    foreach (pat_buf[i]) pat_buf[i] = 8'hFF;
                    pat_len_w = 6'd63;
                end
                1: begin
                    foreach (pat_buf[i]) pat_buf[i] = 8'h00;
                    pat_len_w = 6'd32;
                end
                2: begin
                    foreach (pat_buf[i]) pat_buf[i] = 8'($urandom_range(255));
                    pat_len_w = 6'd0;
                end
                default: begin
                    make_pattern();
                end
            endcase
            if (phase % 7 == 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 30;
                rx_idle_pct = 30;
            end
            load_pattern();
            if (phase == 5) begin
                hold_req = 1'b1;
                n_texts = 40;
            end else begin
                n_texts = $urandom_range(4, 12);
            end
            repeat (n_texts) begin
                build_text();
                send_text();
            end
            phase++;
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
